/* src/json_string_unescape_utf8_macros.svh */
// Assertion macros for the JSON string unescaper checker.
// Stand-alone header: no dependencies beyond the including file's clock and reset.
`ifndef JSON_STRING_UNESCAPE_UTF8_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JSU_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define JSU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/jsu_pkg.sv */
// Shared types, character codes and helper functions for the JSON string unescaper.
// No dependencies; imported by every module of the block.
package jsu_pkg;

  localparam int unsigned MaxResults = 6;

  // Characters of interest in the source text
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  // Control codes produced by the simple escapes
  localparam logic [7:0] CODE_BS = 8'h08;
  localparam logic [7:0] CODE_FF = 8'h0C;
  localparam logic [7:0] CODE_LF = 8'h0A;
  localparam logic [7:0] CODE_CR = 8'h0D;
  localparam logic [7:0] CODE_HT = 8'h09;

  // UTF-16 surrogate ranges and the replacement character
  localparam logic [15:0] HIGH_SUR_LO = 16'hD800;
  localparam logic [15:0] HIGH_SUR_HI = 16'hDBFF;
  localparam logic [15:0] LOW_SUR_LO  = 16'hDC00;
  localparam logic [15:0] LOW_SUR_HI  = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE   = 21'h10000;
  localparam logic [20:0] REPL_CHAR   = 21'h00FFFD;
  localparam logic [7:0]  REPL_B0     = 8'hEF;
  localparam logic [7:0]  REPL_B1     = 8'hBF;
  localparam logic [7:0]  REPL_B2     = 8'hBD;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_STR     = 3'd1,
    MODE_ESC     = 3'd2,
    MODE_HEX     = 3'd3,
    MODE_HIGH    = 3'd4,
    MODE_HIGH_BS = 3'd5,
    MODE_LOW     = 3'd6
  } mode_e;

  typedef enum logic [2:0] {
    MAIN_NONE,
    MAIN_BYTE,
    MAIN_CP,
    MAIN_DONE,
    MAIN_ERR
  } main_e;

  typedef struct packed {
    mode_e       mode;
    logic [1:0]  hex_cnt;
    logic [15:0] first_unit;
    logic [15:0] second_unit;
  } dec_state_t;

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
  } res_item_t;

  typedef struct packed {
    res_item_t [MaxResults-1:0] item;
    logic [2:0]                 count;
  } res_list_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      len;
  } utf8_t;

  function automatic hex_t hex_value(input logic [7:0] c);
    hex_t r;
    r = '0;
    if (c inside {[8'h30:8'h39]}) begin
      r.ok  = 1'b1;
      r.val = c[3:0];
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      r.ok  = 1'b1;
      r.val = 4'(c[2:0] + 3'd1) + 4'd8;
    end
    return r;
  endfunction

  function automatic utf8_t utf8_encode(input logic [20:0] cp);
    utf8_t r;
    r = '0;
    if (cp <= 21'h7F) begin
      r.len  = 3'd1;
      r.b[0] = cp[7:0];
    end else if (cp <= 21'h7FF) begin
      r.len  = 3'd2;
      r.b[0] = {3'b110, cp[10:6]};
      r.b[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      r.len  = 3'd3;
      r.b[0] = {4'b1110, cp[15:12]};
      r.b[1] = {2'b10, cp[11:6]};
      r.b[2] = {2'b10, cp[5:0]};
    end else begin
      r.len  = 3'd4;
      r.b[0] = {5'b11110, cp[20:18]};
      r.b[1] = {2'b10, cp[17:12]};
      r.b[2] = {2'b10, cp[11:6]};
      r.b[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

endpackage

/* src/json_string_unescape_utf8.sv */
// Top level of the JSON string unescaper with UTF-8 output.
// Instantiates jsu_decode and jsu_result_buf; depends on jsu_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one source byte per word, with
//   start_req_i marking the opening quote of a new string and text_end_i the last byte
//   of the text. Output channel (out_valid_o / out_ready_i) carries one result per word:
//   a UTF-8 value byte (kind 0), string complete (kind 1) or error (kind 2); last_o
//   flags the final result caused by a given source byte. A byte may cause no result.
//   The first result of a byte is offered after the byte has passed through the input
//   register and been decoded into the result buffer.
//   Throughput: one byte per cycle while each byte gives at most one result and
//   out_ready_i stays high; a byte giving n results holds the result buffer until
//   all n are taken (up to six for a failed surrogate pair followed by a three-byte
//   character). The single result buffer, drained one word a cycle, sets that figure.
//   Reset: asynchronous, active low; returns the decoder to idle and empties both the
//   input register and the result buffer.
//   Stall: while out_ready_i is low the current result holds; one more byte may wait in
//   the input register, after which in_ready_o drops until the buffer drains.
module json_string_unescape_utf8 import jsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       start_req_i,
  input  logic       text_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] kind_o,
  output logic       last_o
);

  // Input register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_start_q;
  logic       s1_end_q;

  // Decoder state
  dec_state_t st_q, st_d;

  res_list_t  list;
  logic       list_ready;
  logic       load;

  // The decoder consumes the registered byte when the buffer can take its results
  assign load       = s1_valid_q && list_ready;
  assign in_ready_o = !s1_valid_q || load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      s1_valid_q <= 1'b1;
    end else if (load) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Hold the payload until the decoder takes it
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_byte_q  <= data_byte_i;
      s1_start_q <= start_req_i;
      s1_end_q   <= text_end_i;
    end
  end

  jsu_decode u_decode (
    .st_i        (st_q),
    .data_byte_i (s1_byte_q),
    .start_req_i (s1_start_q),
    .text_end_i  (s1_end_q),
    .st_o        (st_d),
    .res_o       (list)
  );

  // Advance the decoder state only when its results are committed to the buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{mode: MODE_IDLE, hex_cnt: '0, first_unit: '0, second_unit: '0};
    end else if (load) begin
      st_q <= st_d;
    end
  end

  jsu_result_buf u_result_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .list_valid_i (s1_valid_q),
    .list_i       (list),
    .list_ready_o (list_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .kind_o       (kind_o),
    .last_o       (last_o)
  );

endmodule

/* src/jsu_decode.sv */
// Next-state and result-list logic for one source byte of the unescaper.
// Purely combinational; depends on jsu_pkg.
module jsu_decode import jsu_pkg::*; (
  input  dec_state_t st_i,
  input  logic [7:0] data_byte_i,
  input  logic       start_req_i,
  input  logic       text_end_i,
  output dec_state_t st_o,
  output res_list_t  res_o
);

  hex_t             hex;
  logic [15:0]      acc_first;
  logic [15:0]      acc_second;
  logic [15:0]      unit;
  logic             unit_high;
  logic             unit_low;
  logic [20:0]      pair_cp;
  main_e            str_main;
  mode_e            str_mode;
  main_e            esc_main;
  mode_e            esc_mode;
  logic [7:0]       esc_byte;
  logic             pre;
  main_e            main;
  logic [7:0]       main_byte;
  logic [20:0]      main_cp;
  utf8_t            enc;
  res_item_t [3:0]  main_item;
  logic [2:0]       main_len;

  assign hex        = hex_value(data_byte_i);
  assign acc_first  = {st_i.first_unit[11:0], hex.val};
  assign acc_second = {st_i.second_unit[11:0], hex.val};
  assign unit       = (st_i.mode == MODE_LOW) ? acc_second : acc_first;
  assign unit_high  = (unit >= HIGH_SUR_LO) && (unit <= HIGH_SUR_HI);
  assign unit_low   = (unit >= LOW_SUR_LO) && (unit <= LOW_SUR_HI);
  assign pair_cp    = SUPP_BASE + {1'b0, st_i.first_unit[9:0], acc_second[9:0]};

  // Plain string byte
  always_comb begin
    if (data_byte_i == CH_QUOTE) begin
      str_main = MAIN_DONE;
      str_mode = MODE_IDLE;
    end else if (data_byte_i == CH_BSLASH) begin
      str_main = MAIN_NONE;
      str_mode = MODE_ESC;
    end else begin
      str_main = MAIN_BYTE;
      str_mode = MODE_STR;
    end
  end

  // Byte after a backslash
  always_comb begin
    esc_main = MAIN_BYTE;
    esc_mode = MODE_STR;
    esc_byte = data_byte_i;
    case (data_byte_i)
      CH_B: esc_byte = CODE_BS;
      CH_F: esc_byte = CODE_FF;
      CH_N: esc_byte = CODE_LF;
      CH_R: esc_byte = CODE_CR;
      CH_T: esc_byte = CODE_HT;
      CH_U: begin
        esc_main = MAIN_NONE;
        esc_mode = MODE_HEX;
      end
      default: ;
    endcase
  end

  always_comb begin
    st_o      = st_i;
    pre       = 1'b0;
    main      = MAIN_NONE;
    main_byte = data_byte_i;
    main_cp   = '0;
    if (start_req_i) begin
      st_o.hex_cnt     = '0;
      st_o.first_unit  = '0;
      st_o.second_unit = '0;
      if (data_byte_i == CH_QUOTE) begin
        st_o.mode = MODE_STR;
      end else begin
        main      = MAIN_ERR;
        st_o.mode = MODE_IDLE;
      end
    end else begin
      case (st_i.mode)
        MODE_IDLE: ;
        MODE_STR: begin
          main      = str_main;
          st_o.mode = str_mode;
        end
        MODE_ESC: begin
          main      = esc_main;
          main_byte = esc_byte;
          st_o.mode = esc_mode;
          if (esc_mode == MODE_HEX) begin
            st_o.hex_cnt    = '0;
            st_o.first_unit = '0;
          end
        end
        MODE_HEX: begin
          if (!hex.ok) begin
            main         = MAIN_ERR;
            st_o.mode    = MODE_IDLE;
            st_o.hex_cnt = '0;
          end else begin
            st_o.first_unit = acc_first;
            if (st_i.hex_cnt == 2'd3) begin
              st_o.hex_cnt = '0;
              if (unit_high) begin
                st_o.mode = MODE_HIGH;
              end else begin
                main      = MAIN_CP;
                main_cp   = unit_low ? REPL_CHAR : {5'b0, unit};
                st_o.mode = MODE_STR;
              end
            end else begin
              st_o.hex_cnt = st_i.hex_cnt + 2'd1;
            end
          end
        end
        MODE_HIGH: begin
          if (data_byte_i == CH_BSLASH) begin
            st_o.mode = MODE_HIGH_BS;
          end else begin
            pre       = 1'b1;
            main      = str_main;
            st_o.mode = str_mode;
          end
        end
        MODE_HIGH_BS: begin
          if (data_byte_i == CH_U) begin
            st_o.mode        = MODE_LOW;
            st_o.hex_cnt     = '0;
            st_o.second_unit = '0;
          end else begin
            pre       = 1'b1;
            main      = esc_main;
            main_byte = esc_byte;
            st_o.mode = esc_mode;
          end
        end
        MODE_LOW: begin
          if (!hex.ok) begin
            main         = MAIN_ERR;
            st_o.mode    = MODE_IDLE;
            st_o.hex_cnt = '0;
          end else begin
            st_o.second_unit = acc_second;
            if (st_i.hex_cnt == 2'd3) begin
              st_o.hex_cnt = '0;
              if (unit_low) begin
                main      = MAIN_CP;
                main_cp   = pair_cp;
                st_o.mode = MODE_STR;
              end else begin
                // Not a partner: replace the pending high, then retake the value
                pre = 1'b1;
                if (unit_high) begin
                  st_o.first_unit = unit;
                  st_o.mode       = MODE_HIGH;
                end else begin
                  main      = MAIN_CP;
                  main_cp   = {5'b0, unit};
                  st_o.mode = MODE_STR;
                end
              end
            end else begin
              st_o.hex_cnt = st_i.hex_cnt + 2'd1;
            end
          end
        end
        default: st_o.mode = MODE_IDLE;
      endcase
    end

    // End of text with the string still open: drop everything, report error
    if (text_end_i && (st_o.mode != MODE_IDLE)) begin
      pre          = 1'b0;
      main         = MAIN_ERR;
      st_o.mode    = MODE_IDLE;
      st_o.hex_cnt = '0;
    end
  end

  assign enc = utf8_encode(main_cp);

  always_comb begin
    main_item = '0;
    main_len  = '0;
    for (int i = 0; i < 4; i++) begin
      main_item[i].kind = KIND_BYTE;
    end
    case (main)
      MAIN_NONE: ;
      MAIN_BYTE: begin
        main_item[0].data = main_byte;
        main_len          = 3'd1;
      end
      MAIN_DONE: begin
        main_item[0].kind = KIND_DONE;
        main_len          = 3'd1;
      end
      MAIN_ERR: begin
        main_item[0].kind = KIND_ERR;
        main_len          = 3'd1;
      end
      MAIN_CP: begin
        for (int i = 0; i < 4; i++) begin
          main_item[i].data = enc.b[i];
        end
        main_len = enc.len;
      end
      default: ;
    endcase
  end

  // Pack the optional replacement prefix ahead of the main bytes
  always_comb begin
    res_o = '0;
    for (int i = 0; i < MaxResults; i++) begin
      res_o.item[i].kind = KIND_BYTE;
    end
    if (pre) begin
      res_o.item[0].data = REPL_B0;
      res_o.item[1].data = REPL_B1;
      res_o.item[2].data = REPL_B2;
      for (int i = 0; i < 3; i++) begin
        res_o.item[i+3] = main_item[i];
      end
      res_o.count = main_len + 3'd3;
    end else begin
      for (int i = 0; i < 4; i++) begin
        res_o.item[i] = main_item[i];
      end
      res_o.count = main_len;
    end
  end

endmodule

/* src/jsu_result_buf.sv */
// Result buffer: holds one source byte's words; hands out one a cycle unless stalled.
// Depends on jsu_pkg.
module jsu_result_buf import jsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       list_valid_i,
  input  res_list_t  list_i,
  output logic       list_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] kind_o,
  output logic       last_o
);

  res_item_t [MaxResults-1:0] items_q;
  logic [2:0]                 rd_q, rd_d;
  logic [2:0]                 cnt_q, cnt_d;
  logic                       load;
  logic                       take;

  assign out_valid_o  = (rd_q != cnt_q);
  assign last_o       = ((rd_q + 3'd1) == cnt_q);
  assign out_byte_o   = items_q[rd_q].data;
  assign kind_o       = items_q[rd_q].kind;
  assign take         = out_valid_o && out_ready_i;
  assign list_ready_o = !out_valid_o || (take && last_o);
  assign load         = list_valid_i && list_ready_o;

  always_comb begin
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (load) begin
      rd_d  = '0;
      cnt_d = list_i.count;
    end else if (take) begin
      if (last_o) begin
        rd_d  = '0;
        cnt_d = '0;
      end else begin
        rd_d = rd_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      items_q <= list_i.item;
    end
  end

endmodule

/* src/jsu_checker.sv */
// Port-level checker for the JSON string unescaper, bound to the top level.
// Depends on jsu_pkg and json_string_unescape_utf8_macros.svh.
`include "json_string_unescape_utf8_macros.svh"

module jsu_checker import jsu_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic [1:0] kind_i,
  input logic       last_i
);

  // A stalled result word holds
  `JSU_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_byte_i) && $stable(kind_i) && $stable(last_i), "result word changed while stalled")

  // Completion and error always close the results of a byte
  `JSU_ASSERT_IMPLY(a_status_last, clk_i, rst_ni, out_valid_i && (kind_i != KIND_BYTE), last_i, "status word not last")

  // Status words carry a zero byte
  `JSU_ASSERT_IMPLY(a_status_zero, clk_i, rst_ni, out_valid_i && (kind_i != KIND_BYTE), out_byte_i == 8'h00, "status word with non-zero byte")

  // Input back-pressure only while results are pending
  `JSU_ASSERT_IMPLY(a_no_idle_stall, clk_i, rst_ni, !in_ready_i, out_valid_i, "input stalled with no pending result")

endmodule

bind json_string_unescape_utf8 jsu_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_byte_i  (out_byte_o),
  .kind_i      (kind_o),
  .last_i      (last_o)
);
